@@ src/bsa_pkg.sv @@
// Shared types and constants for the bitmap slot allocator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package bsa_pkg;

  // Field widths fixed by the item format
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int SLOT_W    = 8;
  localparam int CNT_W     = 9;
  localparam int CLASS_W   = 16;
  localparam int CFG_W     = 16;
  localparam int STATUS_W  = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLOT_COUNT = 1'b0;
  localparam logic CFG_SIZE_CLASS = 1'b1;

  // Largest slot bound that granted_slot can express
  localparam logic [CNT_W-1:0] SLOT_RANGE = 9'd256;
  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;          // capture item, set word pointer
    logic step;          // advance scan to next word
    logic decide_alloc;  // settle allocate on current word
    logic decide_free;   // settle free on current word
    logic commit;        // move result into output register
  } bsa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic word_full;     // current word has no clear bit
    logic last_word;     // pointer is at the last bitmap word
    logic out_free;      // output register can take a result
  } bsa_stat_t;

endpackage

@@ src/bsa_ctrl.sv @@
// Sequencing state machine of the bitmap slot allocator.
// Depends on bsa_pkg for the command and status structs.
module bsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  bsa_pkg::bsa_stat_t  stat_i,
  output bsa_pkg::bsa_cmd_t   cmd_o
);
  import bsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat_i.word_full || stat_i.last_word) begin
          cmd_o.decide_alloc = 1'b1;
          state_d            = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FREE: begin
        cmd_o.decide_free = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/bsa_datapath.sv @@
// Bitmap words, used counter, config registers and result registers.
// Depends on bsa_pkg; driven by commands from bsa_ctrl.
module bsa_datapath #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bsa_pkg::CFG_W-1:0]     cfg_data_i,
  // item in
  input  logic                          operation_i,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsa_pkg::STATUS_W-1:0]  status_o,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot_o,
  output logic [bsa_pkg::CLASS_W-1:0]   freed_class_o,
  output logic [bsa_pkg::CNT_W-1:0]     used_slots_o,
  // control
  input  bsa_pkg::bsa_cmd_t             cmd_i,
  output bsa_pkg::bsa_stat_t            stat_o
);
  import bsa_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  // Slots at or above 256 can never be granted or freed, so only the
  // first four words can ever hold a set bit.
  localparam int ACT_WORDS = (NUM_WORDS < 4) ? NUM_WORDS : 4;
  localparam int PTR_W     = (ACT_WORDS > 1) ? $clog2(ACT_WORDS) : 1;
  localparam int CMP_W     = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;
  localparam logic [CNT_W-1:0] LIMIT_CAP =
      (MAX_SLOTS < 256) ? CNT_W'(MAX_SLOTS) : SLOT_RANGE;

  logic [WORD_BITS-1:0] occ_q [ACT_WORDS];
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [SLOT_W-1:0]    idx_q;
  logic [CNT_W-1:0]     used_q;
  logic [CNT_W-1:0]     slot_count_q;
  logic [CLASS_W-1:0]   size_class_q;

  logic [STATUS_W-1:0]  res_status_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic [CLASS_W-1:0]   res_class_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [CLASS_W-1:0]   out_class_q;
  logic [CNT_W-1:0]     out_used_q;

  logic [WORD_BITS-1:0] cur_word;
  logic [BIT_W-1:0]     low_clear;
  logic [CNT_W-1:0]     cand_slot;
  logic [CNT_W-1:0]     limit;
  logic                 grant_ok;
  logic                 idx_in_map;
  logic                 free_ok;

  // Current word and its lowest clear bit
  assign cur_word = occ_q[ptr_q];

  always_comb begin
    low_clear = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!cur_word[b]) begin
        low_clear = BIT_W'(b);
      end
    end
  end

  // Allocate and free decisions
  assign cand_slot  = CNT_W'({ptr_q, low_clear});
  assign limit      = (slot_count_q < LIMIT_CAP) ? slot_count_q : LIMIT_CAP;
  assign grant_ok   = !(&cur_word) && (cand_slot < limit);
  assign idx_in_map = CMP_W'(idx_q) < CMP_W'(MAX_SLOTS);
  assign free_ok    = idx_in_map && cur_word[idx_q[BIT_W-1:0]];

  assign stat_o.word_full = &cur_word;
  assign stat_o.last_word = (ptr_q == PTR_W'(ACT_WORDS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // Word pointer
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = (operation_i == OP_FREE) ? PTR_W'(slot_index_i[SLOT_W-1:BIT_W]) : '0;
    end else if (cmd_i.step) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  // Bitmap, counter and pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < ACT_WORDS; w++) begin
        occ_q[w] <= '0;
      end
      used_q <= '0;
      ptr_q  <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.decide_alloc && grant_ok) begin
        occ_q[ptr_q][low_clear] <= 1'b1;
        used_q                  <= used_q + CNT_W'(1);
      end else if (cmd_i.decide_free && free_ok) begin
        occ_q[ptr_q][idx_q[BIT_W-1:0]] <= 1'b0;
        used_q                         <= used_q - CNT_W'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RESET;
      size_class_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLOT_COUNT: slot_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_SIZE_CLASS: size_class_q <= cfg_data_i[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured slot index and pending result (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= slot_index_i;
    end
    if (cmd_i.decide_alloc) begin
      res_status_q <= grant_ok ? ST_OK : ST_NO_FREE;
      res_slot_q   <= grant_ok ? cand_slot[SLOT_W-1:0] : '0;
      res_class_q  <= '0;
    end else if (cmd_i.decide_free) begin
      res_status_q <= free_ok ? ST_OK : ST_NOT_ALLOC;
      res_slot_q   <= '0;
      res_class_q  <= free_ok ? size_class_q : '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_class_q  <= res_class_q;
      out_used_q   <= used_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_slot_q;
  assign freed_class_o  = out_class_q;
  assign used_slots_o   = out_used_q;

endmodule

@@ src/bitmap_slot_allocator_unit.sv @@
// Top level of the bitmap slot allocator: controller plus datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------------------------
//   in      | in_valid_i/in_ready_o  | operation_i, slot_index_i
//   out     | out_valid_o/out_ready_i| status_o, granted_slot_o, freed_class_o,
//           |                        | used_slots_o
//   cfg     | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// A free goes through the FREE and DONE states between acceptances; an allocate
// goes through SCAN, one step per bitmap word, at most four words, then DONE.
// The result enters the output register when the block turns ready again.
// The word scan, one word per cycle, sets the allocate latency.
// One item is in work at a time; the next is taken once the result sits in the
// output register, even if that result has not been taken.
// Reset clears the bitmap and the used count at once; the block is ready
// from the first cycle after reset.
module bitmap_slot_allocator_unit #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bsa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bsa_pkg::STATUS_W-1:0]  status_o,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot_o,
  output logic [bsa_pkg::CLASS_W-1:0]   freed_class_o,
  output logic [bsa_pkg::CNT_W-1:0]     used_slots_o
);
  import bsa_pkg::*;

  bsa_cmd_t  cmd;
  bsa_stat_t stat;

  // Sequencer
  bsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (operation_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Bitmap and result path
  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .granted_slot_o (granted_slot_o),
    .freed_class_o  (freed_class_o),
    .used_slots_o   (used_slots_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

@@ src/bsa_checker.sv @@
// Port-level checks for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_unit.
module bsa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [bsa_pkg::STATUS_W-1:0]  status_o,
  input  logic [bsa_pkg::SLOT_W-1:0]    granted_slot_o,
  input  logic [bsa_pkg::CLASS_W-1:0]   freed_class_o,
  input  logic [bsa_pkg::CNT_W-1:0]     used_slots_o
);
  import bsa_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_slot_o) && $stable(used_slots_o))
    else $error("stalled result changed");

  // One item at a time: after acceptance the input side closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // A failed request carries no slot and no class
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_slot_o == '0 && freed_class_o == '0)
    else $error("failed request carries payload");

  // Status is a known code and the count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_NO_FREE
      || status_o == ST_NOT_ALLOC) && used_slots_o <= SLOT_RANGE)
    else $error("result out of range");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .granted_slot_o (granted_slot_o),
  .freed_class_o  (freed_class_o),
  .used_slots_o   (used_slots_o)
);
